// File: sv/ppe_pkg.sv
`timescale 1ns / 1ps
// Package for the playhead position extrapolator.
// Holds field widths, division constants and the shown-position type; no dependencies.
package ppe_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned LEAD_CFG_W = 16;
  localparam int unsigned CAP_W      = 26;
  localparam int unsigned THR_W      = 36;
  localparam int unsigned EL_W       = 40;
  localparam int unsigned PROD_W     = EL_W + SPEED_W;
  localparam int unsigned Y1_W       = THR_W - 3;
  localparam int unsigned Q1_W       = CAP_W;
  localparam int unsigned M1_W       = Y1_W + 32;
  localparam int unsigned RECIP1_SH  = 38;
  localparam int unsigned Y2_W       = CAP_W - 3;
  localparam int unsigned MS_W       = 17;
  localparam int unsigned M2_W       = Y2_W + MS_W;
  localparam int unsigned RECIP2_SH  = 23;
  localparam int unsigned REM_W      = 10;
  localparam int unsigned SHOWN_W    = POS_W + 1;
  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned LATENCY    = 7;

  localparam logic [31:0]        RECIP1     = 32'd2199023255;
  localparam logic [MS_W-1:0]    RECIP2     = 17'd67108;
  localparam logic [6:0]         DIV_ODD    = 7'd125;
  localparam logic [REM_W-1:0]   US_PER_MS  = 10'd1000;
  localparam logic [19:0]        US_PER_S   = 20'd1000000;
  localparam logic [CAP_W-1:0]   CAP_RST    = 26'd100000;
  localparam logic [THR_W-1:0]   THR_RST    = 36'd100001000;

  typedef struct packed {
    logic [SHOWN_W-1:0] ms;
    logic [REM_W-1:0]   rem;
  } shown_t;

endpackage

// File: sv/playhead_position_extrapolator.sv
`timescale 1ns / 1ps
// Playhead position extrapolator: snapshot re-anchoring, lead extrapolation and clamping.
// Depends on ppe_pkg for widths, reciprocal constants and the shown_t type.
// Results pass each stage and the output register; one input per cycle unless stalled.
// The depth is set by the speed multiplier and the two reciprocal divisions by 1000.
// Stages collapse bubbles, so input is taken while the output stalls if a stage is empty.
// Synchronous active-low reset clears the pipeline, the anchor and the shown position,
// and sets the maximum lead to 100 ms.
module playhead_position_extrapolator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wen,
  input  logic [ppe_pkg::LEAD_CFG_W-1:0]        cfg_wdata,   // max_lead_ms
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // engine position[31:0], track length[63:32], is_playing[64], speed[80:65],
  // time_us[144:81], zero fill[151:145].
  input  logic [ppe_pkg::IN_DATA_W-1:0]         in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ppe_pkg::OUT_DATA_W-1:0]        out_tdata    // shown position[31:0]
);

  logic [ppe_pkg::CAP_W-1:0]   cap_r;
  logic [ppe_pkg::THR_W-1:0]   thr_r;

  logic                        primed_r;
  logic                        was_playing_r;
  logic [ppe_pkg::POS_W-1:0]   anchor_pos_r;
  logic [ppe_pkg::TIME_W-1:0]  anchor_stamp_r;

  logic [7:1]                  go;
  logic [6:1]                  vld_r;
  logic                        out_valid_r;
  logic [ppe_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [ppe_pkg::POS_W-1:0]   in_pos, in_len, pos_cl;
  logic                        in_play, rean_nxt, fwd;
  logic [ppe_pkg::SPEED_W-1:0] in_speed;
  logic [ppe_pkg::TIME_W-1:0]  in_time, stamp_eff;
  logic [ppe_pkg::TIME_W:0]    diff;
  logic                        el_sat_nxt;
  logic [ppe_pkg::EL_W-1:0]    el_nxt;

  logic [ppe_pkg::POS_W-1:0]   pos_r [1:5];
  logic [ppe_pkg::POS_W-1:0]   len_r [1:5];
  logic                        rean_r [1:6];

  logic [ppe_pkg::EL_W-1:0]    s1_el_r;
  logic                        s1_sat_r;
  logic [ppe_pkg::SPEED_W-1:0] s1_speed_r;

  logic [ppe_pkg::PROD_W-1:0]  s2_prod_r;
  logic                        s2_sat_r;

  logic                        big_nxt, s3_big_r;
  logic [ppe_pkg::M1_W-1:0]    m1;
  logic [ppe_pkg::Y1_W-1:0]    s3_y_r;
  logic [ppe_pkg::Q1_W-1:0]    s3_qe_r;

  logic [ppe_pkg::Y1_W-1:0]    r1;
  logic [ppe_pkg::CAP_W-1:0]   lead_nxt, s4_lead_r;

  logic [ppe_pkg::M2_W-1:0]    m2;
  logic [ppe_pkg::CAP_W-1:0]   s5_lead_r;
  logic [ppe_pkg::MS_W-1:0]    s5_qe2_r;

  logic [ppe_pkg::CAP_W-1:0]   r2;
  logic                        carry;
  logic [ppe_pkg::MS_W-1:0]    lead_ms;
  logic [ppe_pkg::REM_W-1:0]   lead_rem;
  ppe_pkg::shown_t             pred_nxt, s6_pred_r, len_us, shown_r, shown_nxt;

  assign in_pos   = in_tdata[31:0];
  assign in_len   = in_tdata[63:32];
  assign in_play  = in_tdata[64];
  assign in_speed = in_tdata[80:65];
  assign in_time  = in_tdata[144:81];

  always_comb begin
    go[7] = !out_valid_r || out_tready;
    for (int k = 6; k >= 1; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  assign in_tready  = go[1];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= ppe_pkg::CAP_RST;
      thr_r <= ppe_pkg::THR_RST;
    end else if (cfg_wen) begin
      cap_r <= ppe_pkg::CAP_W'(cfg_wdata) * ppe_pkg::CAP_W'(ppe_pkg::US_PER_MS);
      thr_r <= ppe_pkg::THR_W'(cfg_wdata) * ppe_pkg::THR_W'(ppe_pkg::US_PER_S)
             + ppe_pkg::THR_W'(ppe_pkg::US_PER_MS);
    end
  end

  always_comb begin
    pos_cl     = (in_len != '0 && in_pos > in_len) ? in_len : in_pos;
    fwd        = pos_cl != anchor_pos_r;
    rean_nxt   = in_speed == '0 || !primed_r || !in_play || !was_playing_r ||
                 pos_cl < anchor_pos_r;
    stamp_eff  = (rean_nxt || fwd) ? in_time : anchor_stamp_r;
    diff       = {1'b0, in_time} - {1'b0, stamp_eff};
    el_sat_nxt = !diff[ppe_pkg::TIME_W] &&
                 (diff[ppe_pkg::TIME_W-1:ppe_pkg::EL_W] != '0);
    el_nxt     = diff[ppe_pkg::TIME_W] ? '0 : diff[ppe_pkg::EL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r       <= 1'b0;
      was_playing_r  <= 1'b0;
      anchor_pos_r   <= '0;
      anchor_stamp_r <= '0;
    end else if (in_tvalid && go[1]) begin
      primed_r      <= 1'b1;
      was_playing_r <= in_play;
      if (rean_nxt || fwd) begin
        anchor_pos_r   <= pos_cl;
        anchor_stamp_r <= in_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go[1]) begin
        vld_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (go[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (go[7]) begin
        out_valid_r <= vld_r[6];
      end
    end
  end

  always_comb begin
    big_nxt = s2_sat_r || (s2_prod_r[ppe_pkg::PROD_W-1:ppe_pkg::THR_W] != '0) ||
              (s2_prod_r[ppe_pkg::THR_W-1:0] >= thr_r);
    m1      = ppe_pkg::M1_W'(s2_prod_r[ppe_pkg::THR_W-1:3]) *
              ppe_pkg::M1_W'(ppe_pkg::RECIP1);
    r1      = s3_y_r - ppe_pkg::Y1_W'(s3_qe_r) * ppe_pkg::Y1_W'(ppe_pkg::DIV_ODD);
    if (s3_big_r) begin
      lead_nxt = cap_r;
    end else if (r1 >= ppe_pkg::Y1_W'(ppe_pkg::DIV_ODD)) begin
      lead_nxt = s3_qe_r + ppe_pkg::Q1_W'(1);
    end else begin
      lead_nxt = s3_qe_r;
    end
    m2      = ppe_pkg::M2_W'(s4_lead_r[ppe_pkg::CAP_W-1:3]) *
              ppe_pkg::M2_W'(ppe_pkg::RECIP2);
  end

  always_comb begin
    r2       = s5_lead_r - ppe_pkg::CAP_W'(s5_qe2_r) * ppe_pkg::CAP_W'(ppe_pkg::US_PER_MS);
    carry    = r2 >= ppe_pkg::CAP_W'(ppe_pkg::US_PER_MS);
    lead_ms  = s5_qe2_r + ppe_pkg::MS_W'(carry);
    lead_rem = carry ? ppe_pkg::REM_W'(r2 - ppe_pkg::CAP_W'(ppe_pkg::US_PER_MS))
                     : ppe_pkg::REM_W'(r2);
    len_us.ms  = ppe_pkg::SHOWN_W'(len_r[5]);
    len_us.rem = '0;
    pred_nxt.ms  = ppe_pkg::SHOWN_W'(pos_r[5]) + ppe_pkg::SHOWN_W'(lead_ms);
    pred_nxt.rem = lead_rem;
    if (rean_r[5]) begin
      pred_nxt.ms  = ppe_pkg::SHOWN_W'(pos_r[5]);
      pred_nxt.rem = '0;
    end else if (len_r[5] != '0 && pred_nxt > len_us) begin
      pred_nxt = len_us;
    end
  end

  always_comb begin
    if (rean_r[6] || s6_pred_r > shown_r) begin
      shown_nxt = s6_pred_r;
    end else begin
      shown_nxt = shown_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      pos_r[1]   <= pos_cl;
      len_r[1]   <= in_len;
      rean_r[1]  <= rean_nxt;
      s1_el_r    <= el_nxt;
      s1_sat_r   <= el_sat_nxt;
      s1_speed_r <= in_speed;
    end
    for (int k = 2; k <= 5; k++) begin
      if (go[k]) begin
        pos_r[k] <= pos_r[k-1];
        len_r[k] <= len_r[k-1];
      end
    end
    for (int k = 2; k <= 6; k++) begin
      if (go[k]) begin
        rean_r[k] <= rean_r[k-1];
      end
    end
    if (go[2]) begin
      s2_prod_r <= ppe_pkg::PROD_W'(s1_el_r) * ppe_pkg::PROD_W'(s1_speed_r);
      s2_sat_r  <= s1_sat_r;
    end
    if (go[3]) begin
      s3_big_r <= big_nxt;
      s3_y_r   <= s2_prod_r[ppe_pkg::THR_W-1:3];
      s3_qe_r  <= m1[ppe_pkg::RECIP1_SH+ppe_pkg::Q1_W-1:ppe_pkg::RECIP1_SH];
    end
    if (go[4]) begin
      s4_lead_r <= lead_nxt;
    end
    if (go[5]) begin
      s5_lead_r <= s4_lead_r;
      s5_qe2_r  <= m2[ppe_pkg::M2_W-1:ppe_pkg::RECIP2_SH];
    end
    if (go[6]) begin
      s6_pred_r <= pred_nxt;
    end
    if (go[7] && vld_r[6]) begin
      out_data_r <= shown_nxt.ms[ppe_pkg::POS_W] ? '1 : shown_nxt.ms[ppe_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r <= '0;
    end else if (go[7] && vld_r[6]) begin
      shown_r <= shown_nxt;
    end
  end

endmodule

// File: sv/ppe_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the playhead position extrapolator, bound to the top level.
// Depends on ppe_pkg for the output width and the pipeline latency.
module ppe_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ppe_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or vanished.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("Input stalled although the output can drain.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, ppe_pkg::LATENCY))
    else $error("Result appeared without a matching input transaction.");

endmodule

bind playhead_position_extrapolator ppe_checker u_ppe_checker (.*);

// File: verif/tb_playhead_position_extrapolator.sv
`timescale 1ns / 1ps
// Self-checking testbench for playhead_position_extrapolator: directed corners, lead limits,
// random playback sessions, output back-pressure and drain pauses. Depends on ppe_pkg.
module tb_playhead_position_extrapolator;

  localparam longint unsigned MICROS_PER_MS = 64'd1000;
  localparam logic [63:0]     ELAPSED_CEIL  = 64'h100_0000_0000;
  localparam logic [63:0]     SHOWN_MASK    = 64'h3FF_FFFF_FFFF;
  localparam int              CYCLE_LIMIT   = 600000;
  localparam int              HOLD_CYCLES   = 300;
  localparam int              MAX_REPORTS   = 10;

  typedef struct packed {
    logic [63:0] time_us;
    logic [15:0] speed_pm;
    logic        is_playing;
    logic [31:0] track_length_ms;
    logic [31:0] pos_ms;
  } snapshot_t;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_wen;
  logic [ppe_pkg::LEAD_CFG_W-1:0]   cfg_wdata;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [ppe_pkg::IN_DATA_W-1:0]    in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [ppe_pkg::OUT_DATA_W-1:0]   out_tdata;

  // Predictor state.
  logic [15:0] lead_limit_ms;
  logic        is_primed;
  logic        prev_playing;
  logic [63:0] anchor_ms;
  logic [63:0] anchor_stamp_us;
  logic [63:0] shown_pos_us;

  logic [31:0] display_q[$];

  int cycle_count;
  int snapshots_taken;
  int positions_checked;
  int mismatch_count;
  int lead_writes;
  int hold_req;
  int quiet_tail;

  // Random session generator state.
  logic [31:0] g_pos;
  logic [31:0] g_len;
  logic [63:0] g_time;
  logic [15:0] g_speed;
  int          g_left;

  playhead_position_extrapolator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d positions outstanding", cycle_count,
               display_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] advance_playhead(input snapshot_t s);
    logic [63:0] pos;
    logic [63:0] len;
    logic [63:0] spd;
    logic [63:0] elapsed;
    logic [63:0] lead;
    logic [63:0] cap;
    logic [63:0] pred;
    logic [63:0] ms;
    pos = {32'd0, s.pos_ms};
    len = {32'd0, s.track_length_ms};
    spd = {48'd0, s.speed_pm};
    if (len != 0 && pos > len) pos = len;
    if (spd == 0 || !is_primed || !s.is_playing || !prev_playing || pos < anchor_ms) begin
      is_primed       = 1'b1;
      prev_playing    = s.is_playing;
      anchor_ms       = pos;
      anchor_stamp_us = s.time_us;
      shown_pos_us    = (pos * MICROS_PER_MS) & SHOWN_MASK;
      return pos[31:0];
    end
    if (pos != anchor_ms) begin
      anchor_ms       = pos;
      anchor_stamp_us = s.time_us;
    end
    elapsed = (s.time_us >= anchor_stamp_us) ? s.time_us - anchor_stamp_us : 64'd0;
    cap = {48'd0, lead_limit_ms} * MICROS_PER_MS;
    if (elapsed >= ELAPSED_CEIL) begin
      lead = cap;
    end else begin
      lead = (elapsed * spd) / MICROS_PER_MS;
      if (lead > cap) lead = cap;
    end
    pred = pos * MICROS_PER_MS + lead;
    if (len != 0 && pred > len * MICROS_PER_MS) pred = len * MICROS_PER_MS;
    pred &= SHOWN_MASK;
    if (pred > shown_pos_us) shown_pos_us = pred;
    prev_playing = s.is_playing;
    ms = shown_pos_us / MICROS_PER_MS;
    return (ms > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ms[31:0];
  endfunction

  // Results are checked before the new snapshot is predicted, both on pre-edge values.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        positions_checked++;
        if (display_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Unexpected result transaction: position %0d", out_tdata);
        end else begin
          want = display_q.pop_front();
          if (out_tdata !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("Position mismatch at result %0d: expected %0d, got %0d",
                       positions_checked, want, out_tdata);
          end
        end
      end
      if (cfg_wen) lead_limit_ms = cfg_wdata;
      if (in_tvalid && in_tready) begin
        snapshots_taken++;
        display_q.push_back(advance_playhead(in_tdata[$bits(snapshot_t)-1:0]));
      end
    end
  end

  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else if (quiet_tail != 0) begin
        out_tready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_snapshot(input snapshot_t s);
    int gap;
    int seen;
    if (quiet_tail == 0 && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    seen      = snapshots_taken;
    in_tdata  = {{(ppe_pkg::IN_DATA_W - $bits(snapshot_t)){1'b0}}, s};
    in_tvalid = 1'b1;
    do @(negedge clk); while (snapshots_taken == seen);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (display_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_max_lead(input logic [15:0] lead);
    wait_drained();
    repeat (ppe_pkg::LATENCY + 3) @(negedge clk);
    cfg_wdata = lead;
    cfg_wen   = 1'b1;
    @(negedge clk);
    cfg_wen   = 1'b0;
    lead_writes++;
  endtask

  function automatic snapshot_t make_snapshot(input logic [31:0] pos, input logic [31:0] len,
                                              input logic play, input logic [15:0] spd,
                                              input logic [63:0] stamp);
    snapshot_t s;
    s.pos_ms          = pos;
    s.track_length_ms = len;
    s.is_playing      = play;
    s.speed_pm        = spd;
    s.time_us         = stamp;
    return s;
  endfunction

  function automatic snapshot_t noise_snapshot();
    return make_snapshot($urandom, ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom,
                         1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                         {$urandom, $urandom});
  endfunction

  task automatic next_session_snapshot(output snapshot_t s);
    int          pick;
    logic [63:0] dt;
    logic [63:0] step;
    logic        play;
    if (g_left == 0) begin
      g_left = $urandom_range(3, 40);
      pick = $urandom_range(0, 15);
      if (pick < 4) g_len = 32'd0;
      else if (pick == 15) g_len = $urandom;
      else g_len = $urandom_range(1000, 900000);
      if ($urandom_range(0, 15) == 0) g_pos = $urandom;
      else g_pos = $urandom_range(0, (g_len != 0) ? g_len : 2000000);
      pick = $urandom_range(0, 9);
      if (pick < 5) g_speed = 16'd1000;
      else if (pick < 8) g_speed = 16'($urandom_range(1, 4000));
      else if (pick == 8) g_speed = 16'($urandom_range(0, 65535));
      else g_speed = 16'd0;
      if ($urandom_range(0, 7) == 0) g_time = {$urandom, $urandom};
      else g_time = g_time + $urandom_range(0, 5000000);
    end
    g_left--;
    if ($urandom_range(0, 99) < 3) begin
      s = noise_snapshot();
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) dt = ELAPSED_CEIL + $urandom;
    else if (pick < 8) dt = -{32'd0, $urandom_range(1, 100000)};
    else dt = 64'($urandom_range(0, 150000));
    g_time = g_time + dt;
    if (pick >= 8) step = (dt * g_speed) / 64'd1000000;
    else step = 64'($urandom_range(0, 1000));
    pick = $urandom_range(0, 9);
    if (pick >= 3 && pick <= 7) begin
      g_pos = g_pos + step[31:0] + $urandom_range(0, 10);
      if ($urandom_range(0, 1) == 0 && g_pos >= 20) g_pos = g_pos - $urandom_range(0, 20);
    end else if (pick == 8) begin
      g_pos = (g_pos > 5000) ? g_pos - $urandom_range(1, 5000) : 32'd0;
    end else if (pick == 9) begin
      g_pos = g_pos + $urandom_range(1, 200000);
    end
    if ($urandom_range(0, 32) == 0) g_speed = 16'($urandom_range(0, 3000));
    play = ($urandom_range(0, 24) != 0);
    s = make_snapshot(g_pos, g_len, play, g_speed, g_time);
  endtask

  task automatic test_directed_corners();
    logic [63:0] t;
    t = 64'd1000000;
    send_snapshot(make_snapshot(32'd5000, 32'd0, 1'b1, 16'd1000, t));
    t += 50000;
    send_snapshot(make_snapshot(32'd5000, 32'd0, 1'b1, 16'd1000, t));
    t += 10000;
    send_snapshot(make_snapshot(32'd5040, 32'd0, 1'b1, 16'd1000, t));
    t += 500000;
    send_snapshot(make_snapshot(32'd5040, 32'd0, 1'b1, 16'd1000, t));
    send_snapshot(make_snapshot(32'd5040, 32'd0, 1'b1, 16'd1000, t - 64'd2000000));
    send_snapshot(make_snapshot(32'd5040, 32'd0, 1'b1, 16'd1000, t + ELAPSED_CEIL * 2));
    send_snapshot(make_snapshot(32'd3000, 32'd0, 1'b1, 16'd1000, t));
    send_snapshot(make_snapshot(32'd3000, 32'd0, 1'b0, 16'd1000, t));
    send_snapshot(make_snapshot(32'd3000, 32'd0, 1'b1, 16'd1000, t));
    t += 20000;
    send_snapshot(make_snapshot(32'd3000, 32'd0, 1'b1, 16'hFFFF, t));
    send_snapshot(make_snapshot(32'd3010, 32'd0, 1'b1, 16'd0, t));
    send_snapshot(make_snapshot(32'd9000, 32'd8000, 1'b1, 16'd1000, t));
    t += 50000;
    send_snapshot(make_snapshot(32'd8000, 32'd8000, 1'b1, 16'd1000, t));
    send_snapshot(make_snapshot(32'd7990, 32'd8000, 1'b1, 16'd1000, t));
    t += 30000;
    send_snapshot(make_snapshot(32'd7995, 32'd8000, 1'b1, 16'd1000, t));
    send_snapshot(make_snapshot(32'hFFFF_FFFF, 32'd0, 1'b1, 16'd1000, t));
    t += 50000;
    send_snapshot(make_snapshot(32'hFFFF_FFFF, 32'd0, 1'b1, 16'd1000, t));
    send_snapshot(make_snapshot(32'd0, 32'd0, 1'b0, 16'd0, 64'd0));
    send_snapshot(make_snapshot(32'd0, 32'd0, 1'b1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_snapshot(make_snapshot(32'd0, 32'd0, 1'b1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_snapshot(make_snapshot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'd1, 64'd0));
    send_snapshot(make_snapshot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'd1, 64'd999999));
    send_snapshot(make_snapshot(32'd1, 32'd1, 1'b1, 16'd1000, 64'd5));
  endtask

  task automatic test_lead_extremes();
    write_max_lead(16'd0);
    send_snapshot(make_snapshot(32'd2000, 32'd0, 1'b1, 16'd1000, 64'd100));
    send_snapshot(make_snapshot(32'd2000, 32'd0, 1'b1, 16'd1000, 64'd900100));
    send_snapshot(make_snapshot(32'd2000, 32'd0, 1'b1, 16'd1000, ELAPSED_CEIL + 64'd100));
    write_max_lead(16'hFFFF);
    send_snapshot(make_snapshot(32'd2000, 32'd0, 1'b1, 16'd1000, 64'd100));
    send_snapshot(make_snapshot(32'd2000, 32'd0, 1'b1, 16'd1000, 64'd40000100));
    send_snapshot(make_snapshot(32'd2000, 32'd0, 1'b1, 16'd1000, ELAPSED_CEIL + 64'd100));
    send_snapshot(make_snapshot(32'd2000, 32'd0, 1'b1, 16'hFFFF, ELAPSED_CEIL - 64'd1));
    send_snapshot(make_snapshot(32'hFFFF_0000, 32'd0, 1'b1, 16'hFFFF, 64'd0));
    send_snapshot(make_snapshot(32'hFFFF_0000, 32'd0, 1'b1, 16'hFFFF, ELAPSED_CEIL));
    send_snapshot(make_snapshot(32'hFFFF_0000, 32'hFFFF_0100, 1'b1, 16'd1000, ELAPSED_CEIL));
  endtask

  task automatic test_random_sessions(input int count, input logic [15:0] lead);
    snapshot_t s;
    write_max_lead(lead);
    repeat (count) begin
      next_session_snapshot(s);
      send_snapshot(s);
    end
  endtask

  task automatic test_output_backpressure();
    snapshot_t s;
    wait_drained();
    hold_req = 1;
    repeat (50) begin
      next_session_snapshot(s);
      send_snapshot(s);
    end
  endtask

  task automatic test_sender_drain();
    snapshot_t s;
    repeat (4) begin
      repeat (6) begin
        next_session_snapshot(s);
        send_snapshot(s);
      end
      wait_drained();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_wen         = 1'b0;
    cfg_wdata       = '0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    hold_req        = 0;
    quiet_tail      = 0;
    lead_limit_ms   = 16'd100;
    is_primed       = 1'b0;
    prev_playing    = 1'b0;
    anchor_ms       = '0;
    anchor_stamp_us = '0;
    shown_pos_us    = '0;
    g_pos           = '0;
    g_len           = '0;
    g_time          = 64'd1000000;
    g_speed         = 16'd1000;
    g_left          = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_corners();
    test_lead_extremes();
    test_random_sessions(230, 16'd100);
    test_random_sessions(230, 16'd0);
    test_random_sessions(230, 16'hFFFF);
    test_output_backpressure();
    test_random_sessions(230, 16'($urandom_range(0, 65535)));
    test_random_sessions(230, 16'd1);
    test_sender_drain();
    test_random_sessions(230, 16'($urandom_range(0, 65535)));
    quiet_tail = 1;
    test_random_sessions(60, 16'd100);

    wait_drained();
    repeat (ppe_pkg::LATENCY * 3) @(negedge clk);
    $display("Covered %0d snapshots and %0d checked positions over %0d max-lead settings,",
             snapshots_taken, positions_checked, lead_writes);
    $display("with re-anchors, lead limits, clamps, stalls and a long output hold.");
    if (mismatch_count == 0 && display_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d positions still expected", mismatch_count,
               display_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/ppe_pkg.sv
sv/playhead_position_extrapolator.sv
sv/ppe_checker.sv
verif/tb_playhead_position_extrapolator.sv
